// File: hdl/bnn_pkg.sv
// ----------------------------------------------------------------------------
// BNN output layer package
// Shared types and constants for the binary output layer with argmax.
// ----------------------------------------------------------------------------
package bnn_pkg;

  localparam int CLASS_W = 4;
  localparam int ROW_W   = 64;
  localparam int BIAS_W  = 16;
  localparam int LOGIT_W = 17;
  localparam int LANES   = 8;
  localparam int LANE_W  = ROW_W / LANES;
  localparam int LCNT_W  = 4;
  localparam int PCNT_W  = 7;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic rd_en;
    logic rd_first;
    logic rd_last;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_status_t;

endpackage

// File: hdl/bnn_output_layer_argmax.sv
// ----------------------------------------------------------------------------
// BNN output layer with argmax
// Loads per-class weight rows and biases, then classifies hidden vectors.
// ----------------------------------------------------------------------------
//  Channel   Handshake       Payload
//  input     start / busy    command, class_index, weight_row, bias,
//                            hidden_vector
//  result    done strobe     top_class, top_logit
//
// busy stays low for a load beat, so beats may follow back to back. A
// classify beat holds busy while one class row is read from the tables each
// cycle and then while a four-stage read, count, logit and compare pipeline
// drains. done pulses for one cycle, in the last cycle that busy is high.
// Reset clears the controller and the pipeline valids; the tables hold no
// meaningful value until loaded. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module bnn_output_layer_argmax
  import bnn_pkg::*;
#(
  parameter int NUM_CLASSES = 10,
  parameter int HIDDEN_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      command,
  input  logic [CLASS_W-1:0]        class_index,
  input  logic [ROW_W-1:0]          weight_row,
  input  logic signed [BIAS_W-1:0]  bias,
  input  logic [ROW_W-1:0]          hidden_vector,
  output logic                      done,
  output logic [CLASS_W-1:0]        top_class,
  output logic signed [LOGIT_W-1:0] top_logit
);

  dp_cmd_t                        cmd;
  dp_status_t                     status;
  logic [$clog2(NUM_CLASSES)-1:0] rd_addr;

  bnn_ctrl #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  bnn_datapath #(
    .NUM_CLASSES(NUM_CLASSES),
    .HIDDEN_BITS(HIDDEN_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .class_index     (class_index),
    .weight_row      (weight_row),
    .bias            (bias),
    .hidden_vector   (hidden_vector),
    .status          (status),
    .top_class       (top_class),
    .top_logit       (top_logit)
  );

  assign done = status.done;

endmodule

// File: hdl/bnn_ctrl.sv
// ----------------------------------------------------------------------------
// BNN controller
// Accepts commands, steps the class counter and waits for the result.
// ----------------------------------------------------------------------------
module bnn_ctrl
  import bnn_pkg::*;
#(
  parameter int NUM_CLASSES = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           command,
  input  dp_status_t                     status,
  output logic                           busy,
  output dp_cmd_t                        cmd,
  output logic [$clog2(NUM_CLASSES)-1:0] rd_addr
);

  localparam int CW = $clog2(NUM_CLASSES);
  localparam logic [CW-1:0] LAST_CLASS = CW'(NUM_CLASSES - 1);

  ctrl_state_t   state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (start && command == CMD_CLASSIFY) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_next = cnt + CW'(1);
        if (cnt == LAST_CLASS) begin
          state_next = ST_DRAIN;
          cnt_next   = '0;
        end
      end
      ST_DRAIN: begin
        if (status.done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    cmd     = '0;
    busy    = 1'b1;
    rd_addr = cnt;
    unique case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.load    = start && command == CMD_LOAD;
        cmd.capture = start && command == CMD_CLASSIFY;
      end
      ST_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = cnt == '0;
        cmd.rd_last  = cnt == LAST_CLASS;
      end
      ST_DRAIN: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // The result can only appear once every class has been issued.
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    status.done |-> state == ST_DRAIN)
    else $error("result strobe outside drain");

  a_classify_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start && command == CMD_CLASSIFY)
      |=> (state == ST_SCAN && cnt == '0))
    else $error("classify did not start the scan at class zero");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cnt == LAST_CLASS) |=> state == ST_DRAIN)
    else $error("scan did not end after the last class");

endmodule

// File: hdl/bnn_datapath.sv
// ----------------------------------------------------------------------------
// BNN datapath
// Weight and bias tables, XNOR popcount pipeline and running argmax.
// ----------------------------------------------------------------------------
module bnn_datapath
  import bnn_pkg::*;
#(
  parameter int NUM_CLASSES = 10,
  parameter int HIDDEN_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dp_cmd_t                        cmd,
  input  logic [$clog2(NUM_CLASSES)-1:0] rd_addr,
  input  logic [CLASS_W-1:0]             class_index,
  input  logic [ROW_W-1:0]               weight_row,
  input  logic signed [BIAS_W-1:0]       bias,
  input  logic [ROW_W-1:0]               hidden_vector,
  output dp_status_t                     status,
  output logic [CLASS_W-1:0]             top_class,
  output logic signed [LOGIT_W-1:0]      top_logit
);

  localparam int AW = $clog2(NUM_CLASSES);
  localparam logic [ROW_W-1:0] USED_MASK = {ROW_W{1'b1}} >> (ROW_W - HIDDEN_BITS);

  logic [ROW_W-1:0]        weight_mem [NUM_CLASSES];
  logic [BIAS_W-1:0]       bias_mem   [NUM_CLASSES];
  logic [ROW_W-1:0]        hid;
  logic                    class_ok;

  // Stage 1: table read.
  logic                    v1, first1, last1;
  logic [AW-1:0]           cls1;
  logic [ROW_W-1:0]        row1;
  logic [BIAS_W-1:0]       bias1;
  // Stage 2: per-lane agreement counts.
  logic                    v2, first2, last2;
  logic [AW-1:0]           cls2;
  logic [LCNT_W-1:0]       lane_cnt2 [LANES];
  logic [LCNT_W-1:0]       lane_cnt_next [LANES];
  logic [BIAS_W-1:0]       bias2;
  // Stage 3: logit.
  logic                    v3, first3, last3;
  logic [AW-1:0]           cls3;
  logic signed [LOGIT_W-1:0] logit3, logit_next;
  logic [PCNT_W-1:0]       pcnt;
  // Running best.
  logic signed [LOGIT_W-1:0] best;
  logic [AW-1:0]           best_cls;
  logic                    done;
  logic                    take;
  logic [ROW_W-1:0]        agree;

  assign class_ok = {1'b0, class_index} < (CLASS_W + 1)'(NUM_CLASSES);

  always_ff @(posedge clk) begin
    if (cmd.load && class_ok) begin
      weight_mem[class_index[AW-1:0]] <= weight_row;
      bias_mem[class_index[AW-1:0]]   <= bias;
    end
    if (cmd.capture) begin
      hid <= hidden_vector;
    end
    if (cmd.rd_en) begin
      row1  <= weight_mem[rd_addr];
      bias1 <= bias_mem[rd_addr];
    end
  end

  assign agree = ~(hid ^ row1) & USED_MASK;

  always_comb begin
    logic [LCNT_W-1:0] c;
    for (int b = 0; b < LANES; b++) begin
      c = '0;
      for (int k = 0; k < LANE_W; k++) begin
        c = c + LCNT_W'(agree[b * LANE_W + k]);
      end
      lane_cnt_next[b] = c;
    end
  end

  always_comb begin
    logic [PCNT_W-1:0] s;
    s = '0;
    for (int b = 0; b < LANES; b++) begin
      s = s + PCNT_W'(lane_cnt2[b]);
    end
    pcnt = s;
  end

  // Logit is twice the agreement count, less the hidden width, plus the bias.
  assign logit_next = $signed({{(LOGIT_W - PCNT_W - 1){1'b0}}, pcnt, 1'b0})
                      - LOGIT_W'(HIDDEN_BITS)
                      + $signed({bias2[BIAS_W-1], bias2});

  // The first class is always taken; later ones only on a strictly larger logit.
  assign take = v3 && (first3 || logit3 > best);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= cmd.rd_en;
      v2   <= v1;
      v3   <= v2;
      done <= v3 && last3;
    end
  end

  always_ff @(posedge clk) begin
    first1 <= cmd.rd_first;
    last1  <= cmd.rd_last;
    cls1   <= rd_addr;
    first2 <= first1;
    last2  <= last1;
    cls2   <= cls1;
    bias2  <= bias1;
    for (int b = 0; b < LANES; b++) begin
      lane_cnt2[b] <= lane_cnt_next[b];
    end
    first3 <= first2;
    last3  <= last2;
    cls3   <= cls2;
    logit3 <= logit_next;
    if (take) begin
      best     <= logit3;
      best_cls <= cls3;
    end
  end

  assign status.done = done;
  assign top_class   = CLASS_W'(best_cls);
  assign top_logit   = best;

endmodule
